// ===== src/tsd_pkg.sv =====
// Shared constants and types for the tetrahedron shape-gradient block.
// No dependencies; imported by every module of the block.
package tsd_pkg;

	localparam int COORD_W_DEF = 32;   // default coordinate width
	localparam int FRAC_DEF    = 16;   // default fraction bits
	localparam int GRAD_W      = 32;   // gradient component width
	localparam int VOL_W       = 64;   // volume width
	localparam int VOL_FRAC    = 32;   // volume fraction bits
	localparam int SLOT_W      = 2;

	localparam logic [SLOT_W-1:0] SLOT_FIRST = 2'd0;
	localparam logic [SLOT_W-1:0] SLOT_LAST  = 2'd3;
	localparam logic [3:0]        VOL_DIV    = 4'd6;

	// control tag that travels with each gradient row
	typedef struct packed {
		logic [SLOT_W-1:0] slot;
		logic              last;
	} row_tag_t;

endpackage

// ===== src/tsd_front.sv =====
// Element front end: edge vectors, cross products and Jacobian determinant.
// Five register stages under one advance enable; depends on tsd_pkg.
module tsd_front #(
	parameter int W = tsd_pkg::COORD_W_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         en,
	input  logic                         in_valid,
	input  logic signed [W-1:0]          vtx [4][3],
	output logic                         out_valid,
	output logic signed [2*(W+1)+2:0]    nrm [4][3],
	output logic signed [3*(W+1)+2:0]    det
);
	import tsd_pkg::*;

	localparam int EW   = W + 1;
	localparam int PW   = 2 * EW;
	localparam int NW   = PW + 1;
	localparam int NUMW = NW + 2;
	localparam int HW   = NW / 2;
	localparam int HIW  = NW - HW;
	localparam int DW   = EW + NW + 2;

	logic v_s1, v_s2, v_s3, v_s4, v_s5;

	logic signed [EW-1:0]      e_s1  [3][3];
	logic signed [PW-1:0]      pa_s2 [3][3];
	logic signed [PW-1:0]      pb_s2 [3][3];
	logic signed [EW-1:0]      e0_s2 [3];
	logic signed [NW-1:0]      n_s3  [3][3];
	logic signed [EW-1:0]      e0_s3 [3];
	logic signed [NUMW-1:0]    n_s4  [4][3];
	logic signed [EW+HW:0]     plo_s4 [3];
	logic signed [EW+HIW-1:0]  phi_s4 [3];
	logic signed [NUMW-1:0]    n_s5  [4][3];
	logic signed [DW-1:0]      det_s5;
	logic signed [DW-1:0]      det_sum;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	always_comb begin
		det_sum = '0;
		for (int k = 0; k < 3; k++) begin
			det_sum = det_sum + (DW'(phi_s4[k]) <<< HW) + DW'(plo_s4[k]);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			// edges from vertex 0
			for (int i = 0; i < 3; i++) begin
				for (int k = 0; k < 3; k++) begin
					e_s1[i][k] <= EW'(vtx[i+1][k]) - EW'(vtx[0][k]);
				end
			end
			// cross product terms: n1 = e1 x e2, n2 = e2 x e0, n3 = e0 x e1
			for (int j = 0; j < 3; j++) begin
				for (int k = 0; k < 3; k++) begin
					pa_s2[j][k] <= PW'(e_s1[(j+1)%3][(k+1)%3]) * PW'(e_s1[(j+2)%3][(k+2)%3]);
					pb_s2[j][k] <= PW'(e_s1[(j+1)%3][(k+2)%3]) * PW'(e_s1[(j+2)%3][(k+1)%3]);
				end
				e0_s2[j] <= e_s1[0][j];
			end
			for (int j = 0; j < 3; j++) begin
				for (int k = 0; k < 3; k++) begin
					n_s3[j][k] <= NW'(pa_s2[j][k]) - NW'(pb_s2[j][k]);
				end
				e0_s3[j] <= e0_s2[j];
			end
			// vertex 0 gradient numerator and split determinant products
			for (int k = 0; k < 3; k++) begin
				n_s4[0][k] <= -(NUMW'(n_s3[0][k]) + NUMW'(n_s3[1][k]) + NUMW'(n_s3[2][k]));
				for (int j = 0; j < 3; j++) begin
					n_s4[j+1][k] <= NUMW'(n_s3[j][k]);
				end
				plo_s4[k] <= (EW+HW+1)'(e0_s3[k]) * $signed({1'b0, n_s3[0][k][HW-1:0]});
				phi_s4[k] <= (EW+HIW)'(e0_s3[k]) * (EW+HIW)'($signed(n_s3[0][k][NW-1:HW]));
			end
			n_s5   <= n_s4;
			det_s5 <= det_sum;
		end
	end

	assign out_valid = v_s5;
	assign nrm       = n_s5;
	assign det       = det_s5;

endmodule

// ===== src/tsd_grad.sv =====
// Row back end: restoring dividers for three gradient components,
// volume divide by six, saturation and the output register; uses tsd_pkg.
module tsd_grad #(
	parameter int W = tsd_pkg::COORD_W_DEF,
	parameter int F = tsd_pkg::FRAC_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              row_valid,
	input  tsd_pkg::row_tag_t                 row_tag,
	input  logic signed [2*(W+1)+2:0]         num [3],
	input  logic signed [3*(W+1)+2:0]         det,
	input  logic                              out_ready,
	output logic                              adv,
	output logic                              out_valid,
	output logic [tsd_pkg::SLOT_W-1:0]        out_slot,
	output logic signed [tsd_pkg::GRAD_W-1:0] out_grad [3],
	output logic [tsd_pkg::VOL_W-1:0]         out_vol,
	output logic                              out_degen,
	output logic                              out_last
);
	import tsd_pkg::*;

	localparam int EW   = W + 1;
	localparam int NUMW = 2 * EW + 3;
	localparam int DW   = 3 * EW + 3;
	localparam int QW   = GRAD_W + 1;
	localparam int XW   = NUMW + 2 * F;
	localparam int RW   = (XW > DW + QW) ? XW : DW + QW;
	localparam int VS   = 3 * F - VOL_FRAC;
	localparam int VSHL = (VS < 0) ? -VS : 0;
	localparam int VSR  = (VS > 0) ? VS : 0;
	localparam int VXW  = DW + VSHL;
	localparam int VXQ  = (VXW > VOL_W) ? VXW : VOL_W + 1;
	localparam int VST  = (VXQ + 7) / 8;
	localparam int VXP  = VST * 8;
	localparam logic [QW-1:0] POS_LIM = QW'((64'd1 << (GRAD_W - 1)) - 64'd1);
	localparam logic [QW-1:0] NEG_LIM = QW'(64'd1 << (GRAD_W - 1));

	logic            vld_sk [QW+1];
	row_tag_t        tag_sk [QW+1];
	logic            deg_sk [QW+1];
	logic [2:0]      neg_sk [QW+1];
	logic [2:0]      ovf_sk [QW+1];
	logic [RW-1:0]   rem_sk [QW+1][3];
	logic [QW-1:0]   quo_sk [QW+1][3];
	logic [DW-1:0]   den_sk [QW+1];
	logic [VXP-1:0]  vx_sk  [QW+1];
	logic [VXP-1:0]  vq_sk  [QW+1];
	logic [2:0]      vr_sk  [QW+1];

	logic [NUMW-1:0] absn [3];
	logic [DW-1:0]   absd;
	logic [RW-1:0]   dtop;

	// eight quotient bits of a divide by six, remainder carried in
	function automatic logic [10:0] div6_byte(input logic [2:0] r_in, input logic [7:0] d);
		logic [3:0] r;
		logic [7:0] q;
		r = {1'b0, r_in};
		q = '0;
		for (int b = 7; b >= 0; b--) begin
			r = {r[2:0], d[b]};
			if (r >= VOL_DIV) begin
				r    = r - VOL_DIV;
				q[b] = 1'b1;
			end
		end
		return {r[2:0], q};
	endfunction

	assign adv = !out_valid || out_ready;

	always_comb begin
		for (int c = 0; c < 3; c++) begin
			absn[c] = num[c][NUMW-1] ? NUMW'(-num[c]) : NUMW'(num[c]);
		end
		absd = det[DW-1] ? DW'(-det) : DW'(det);
		dtop = RW'(absd) << QW;
	end

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int j = 0; j <= QW; j++) begin
				vld_sk[j] <= 1'b0;
			end
			out_valid <= 1'b0;
		end else if (adv) begin
			vld_sk[0] <= row_valid;
			for (int j = 1; j <= QW; j++) begin
				vld_sk[j] <= vld_sk[j-1];
			end
			out_valid <= vld_sk[QW];
		end
	end

	// prepare: magnitudes, signs and overflow test
	always_ff @(posedge clk) begin
		if (adv) begin
			tag_sk[0] <= row_tag;
			deg_sk[0] <= (absd == '0);
			den_sk[0] <= absd;
			for (int c = 0; c < 3; c++) begin
				rem_sk[0][c] <= RW'(absn[c]) << (2 * F);
				quo_sk[0][c] <= '0;
				neg_sk[0][c] <= num[c][NUMW-1] ^ det[DW-1];
				ovf_sk[0][c] <= ((RW'(absn[c]) << (2 * F)) >= dtop);
			end
			vx_sk[0] <= (VXP'(absd) << VSHL) >> VSR;
			vq_sk[0] <= '0;
			vr_sk[0] <= '0;
		end
	end

	// one quotient bit per stage, MSB first
	for (genvar j = 1; j <= QW; j++) begin : g_div
		localparam int BI = QW - j;
		logic [RW-1:0] dsh;
		logic [10:0]   vstep;

		assign dsh   = RW'(den_sk[j-1]) << BI;
		assign vstep = div6_byte(vr_sk[j-1], vx_sk[j-1][VXP-1 -: 8]);

		always_ff @(posedge clk) begin
			if (adv) begin
				tag_sk[j] <= tag_sk[j-1];
				deg_sk[j] <= deg_sk[j-1];
				den_sk[j] <= den_sk[j-1];
				neg_sk[j] <= neg_sk[j-1];
				ovf_sk[j] <= ovf_sk[j-1];
				for (int c = 0; c < 3; c++) begin
					if (rem_sk[j-1][c] >= dsh) begin
						rem_sk[j][c] <= rem_sk[j-1][c] - dsh;
						quo_sk[j][c] <= {quo_sk[j-1][c][QW-2:0], 1'b1};
					end else begin
						rem_sk[j][c] <= rem_sk[j-1][c];
						quo_sk[j][c] <= {quo_sk[j-1][c][QW-2:0], 1'b0};
					end
				end
				if (j <= VST) begin
					vx_sk[j] <= vx_sk[j-1] << 8;
					vq_sk[j] <= {vq_sk[j-1][VXP-9:0], vstep[7:0]};
					vr_sk[j] <= vstep[10:8];
				end else begin
					vx_sk[j] <= vx_sk[j-1];
					vq_sk[j] <= vq_sk[j-1];
					vr_sk[j] <= vr_sk[j-1];
				end
			end
		end
	end

	// saturate, apply sign, register the result
	always_ff @(posedge clk) begin
		if (adv) begin
			out_slot  <= tag_sk[QW].slot;
			out_last  <= tag_sk[QW].last;
			out_degen <= deg_sk[QW];
			for (int c = 0; c < 3; c++) begin
				if (deg_sk[QW]) begin
					out_grad[c] <= '0;
				end else if (neg_sk[QW][c]) begin
					if (ovf_sk[QW][c] || quo_sk[QW][c] > NEG_LIM) begin
						out_grad[c] <= GRAD_W'(NEG_LIM);
					end else begin
						out_grad[c] <= GRAD_W'(-quo_sk[QW][c]);
					end
				end else begin
					if (ovf_sk[QW][c] || quo_sk[QW][c] > POS_LIM) begin
						out_grad[c] <= GRAD_W'(POS_LIM);
					end else begin
						out_grad[c] <= GRAD_W'(quo_sk[QW][c]);
					end
				end
			end
			if (deg_sk[QW]) begin
				out_vol <= '0;
			end else if (|vq_sk[QW][VXP-1:VOL_W]) begin
				out_vol <= '1;
			end else begin
				out_vol <= vq_sk[QW][VOL_W-1:0];
			end
		end
	end

endmodule

// ===== src/tetra_shape_derivatives.sv =====
// Top level of the linear tetrahedron shape-gradient block.
// Instantiates tsd_front and tsd_grad; uses tsd_pkg.
//
// Use: one request on the input channel (in_valid/in_ready) carries the four
// vertex positions of a tetrahedron, signed fixed point with FRAC_BITS
// fraction bits. Each request yields four results on the output channel
// (out_valid/out_ready), one per vertex in order 0..3: the shape-function
// gradient, the element volume |det|/6 in Q32.32, a degenerate flag when
// the determinant is zero (gradients and volume then zero), and last on the
// fourth result.
// From an accepted request to its first result: five front stages, one row
// serialiser, one prepare stage, 33 divider stages, one output register. The
// serialiser hands one vertex row per cycle to the divider chain while the
// chain advances, taking the next request as the last held row leaves.
// The front end buffers up to five further requests before in_ready drops.
// Reset clears all valid bits; no request or result is in flight after it.
// When out_valid is high and out_ready low, the whole divider chain holds,
// the serialiser holds its row and the front end fills, then back-pressures.
module tetra_shape_derivatives #(
	parameter int COORD_WIDTH = tsd_pkg::COORD_W_DEF,
	parameter int FRAC_BITS   = tsd_pkg::FRAC_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic signed [COORD_WIDTH-1:0]      v0_x,
	input  logic signed [COORD_WIDTH-1:0]      v0_y,
	input  logic signed [COORD_WIDTH-1:0]      v0_z,
	input  logic signed [COORD_WIDTH-1:0]      v1_x,
	input  logic signed [COORD_WIDTH-1:0]      v1_y,
	input  logic signed [COORD_WIDTH-1:0]      v1_z,
	input  logic signed [COORD_WIDTH-1:0]      v2_x,
	input  logic signed [COORD_WIDTH-1:0]      v2_y,
	input  logic signed [COORD_WIDTH-1:0]      v2_z,
	input  logic signed [COORD_WIDTH-1:0]      v3_x,
	input  logic signed [COORD_WIDTH-1:0]      v3_y,
	input  logic signed [COORD_WIDTH-1:0]      v3_z,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic [tsd_pkg::SLOT_W-1:0]         vertex_slot,
	output logic signed [tsd_pkg::GRAD_W-1:0]  grad_x,
	output logic signed [tsd_pkg::GRAD_W-1:0]  grad_y,
	output logic signed [tsd_pkg::GRAD_W-1:0]  grad_z,
	output logic [tsd_pkg::VOL_W-1:0]          elem_volume,
	output logic                               degenerate,
	output logic                               last
);
	import tsd_pkg::*;

	localparam int EW   = COORD_WIDTH + 1;
	localparam int NUMW = 2 * EW + 3;
	localparam int DW   = 3 * EW + 3;

	logic signed [COORD_WIDTH-1:0] vtx [4][3];
	logic                          front_en;
	logic                          f_valid;
	logic signed [NUMW-1:0]        f_nrm [4][3];
	logic signed [DW-1:0]          f_det;

	// serialiser: holds one element and issues its four vertex rows
	logic                          ser_busy_q;
	logic [SLOT_W-1:0]             ser_cnt_q;
	logic signed [NUMW-1:0]        ser_n_q [4][3];
	logic signed [DW-1:0]          ser_det_q;
	logic                          ser_done;
	logic                          ser_load;
	row_tag_t                      row_tag;
	logic                          adv;
	logic signed [GRAD_W-1:0]      grad [3];

	assign vtx[0][0] = v0_x;
	assign vtx[0][1] = v0_y;
	assign vtx[0][2] = v0_z;
	assign vtx[1][0] = v1_x;
	assign vtx[1][1] = v1_y;
	assign vtx[1][2] = v1_z;
	assign vtx[2][0] = v2_x;
	assign vtx[2][1] = v2_y;
	assign vtx[2][2] = v2_z;
	assign vtx[3][0] = v3_x;
	assign vtx[3][1] = v3_y;
	assign vtx[3][2] = v3_z;

	// drop the held element once its last row leaves, load the next at once
	assign ser_done = ser_busy_q && adv && (ser_cnt_q == SLOT_LAST);
	assign ser_load = !ser_busy_q || ser_done;
	// advance the front end whenever its last stage is empty or drains
	assign front_en = !f_valid || ser_load;
	assign in_ready = front_en;

	assign row_tag.slot = ser_cnt_q;
	assign row_tag.last = (ser_cnt_q == SLOT_LAST);

	tsd_front #(
		.W (COORD_WIDTH)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (front_en),
		.in_valid  (in_valid),
		.vtx       (vtx),
		.out_valid (f_valid),
		.nrm       (f_nrm),
		.det       (f_det)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ser_busy_q <= 1'b0;
			ser_cnt_q  <= SLOT_FIRST;
		end else if (ser_load) begin
			ser_busy_q <= f_valid;
			ser_cnt_q  <= SLOT_FIRST;
		end else if (adv) begin
			ser_cnt_q <= ser_cnt_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (ser_load && f_valid) begin
			ser_n_q   <= f_nrm;
			ser_det_q <= f_det;
		end
	end

	tsd_grad #(
		.W (COORD_WIDTH),
		.F (FRAC_BITS)
	) u_grad (
		.clk       (clk),
		.arst_n    (arst_n),
		.row_valid (ser_busy_q),
		.row_tag   (row_tag),
		.num       (ser_n_q[ser_cnt_q]),
		.det       (ser_det_q),
		.out_ready (out_ready),
		.adv       (adv),
		.out_valid (out_valid),
		.out_slot  (vertex_slot),
		.out_grad  (grad),
		.out_vol   (elem_volume),
		.out_degen (degenerate),
		.out_last  (last)
	);

	assign grad_x = grad[0];
	assign grad_y = grad[1];
	assign grad_z = grad[2];

endmodule

// ===== src/tsd_checker.sv =====
// Port-level checks for tetra_shape_derivatives, attached by bind.
// Depends on tsd_pkg for field widths.
module tsd_checker (
	input logic                               clk,
	input logic                               arst_n,
	input logic                               out_valid,
	input logic                               out_ready,
	input logic [tsd_pkg::SLOT_W-1:0]         vertex_slot,
	input logic signed [tsd_pkg::GRAD_W-1:0]  grad_x,
	input logic signed [tsd_pkg::GRAD_W-1:0]  grad_y,
	input logic signed [tsd_pkg::GRAD_W-1:0]  grad_z,
	input logic [tsd_pkg::VOL_W-1:0]          elem_volume,
	input logic                               degenerate,
	input logic                               last
);
	import tsd_pkg::*;

	// a stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(grad_x) && $stable(vertex_slot))
		else $error("result changed while stalled");

	// a flat element reports no gradient and no volume
	a_degen: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && degenerate |-> grad_x == '0 && grad_y == '0 && grad_z == '0
			&& elem_volume == '0)
		else $error("degenerate result not cleared");

	// last marks the vertex 3 row only
	a_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (last == (vertex_slot == SLOT_LAST)))
		else $error("last does not match vertex slot");

	// the four rows of an element share volume and flag; this checks the flag
	a_same: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !last ##1 out_valid |-> $stable(degenerate))
		else $error("degenerate flag changed within an element");

endmodule

bind tetra_shape_derivatives tsd_checker u_tsd_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.out_valid   (out_valid),
	.out_ready   (out_ready),
	.vertex_slot (vertex_slot),
	.grad_x      (grad_x),
	.grad_y      (grad_y),
	.grad_z      (grad_z),
	.elem_volume (elem_volume),
	.degenerate  (degenerate),
	.last        (last)
);
